>>> sv/ascs_pkg.sv
// ---------------------------------------------------------------------------
// ascs_pkg
// Shared types and constants for the Annex B start code splitter.
// ---------------------------------------------------------------------------
package ascs_pkg;

  localparam int OFF_W         = 32;
  localparam int TYPE_W        = 5;
  localparam int QUEUE_DEPTH_D = 4;

  localparam logic [OFF_W-1:0]  POS_MAX   = {OFF_W{1'b1}};
  localparam logic [7:0]        SC_BYTE   = 8'h01;
  localparam logic [7:0]        ZERO_BYTE = 8'h00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]  start_offset;
    logic [OFF_W-1:0]  body_offset;
    logic [OFF_W-1:0]  payload_size;
    logic [TYPE_W-1:0] unit_type;
    logic              last_of_run;
  } out_item_t;

  // one unit record without the run marker
  typedef struct packed {
    logic [OFF_W-1:0]  start;
    logic [OFF_W-1:0]  payload;
    logic [OFF_W-1:0]  size;
    logic [TYPE_W-1:0] utype;
  } rec_t;

  // records caused by one byte; r1 used only when two is set
  typedef struct packed {
    rec_t r0;
    rec_t r1;
    logic two;
  } rec_pair_t;

  function automatic logic [OFF_W-1:0] sat_inc(input logic [OFF_W-1:0] v);
    return (v == POS_MAX) ? POS_MAX : v + OFF_W'(1);
  endfunction

  function automatic logic [OFF_W-1:0] clamp_sub(input logic [OFF_W-1:0] a,
                                                 input logic [OFF_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

endpackage

>>> sv/annexb_start_code_splitter_top.sv
// ---------------------------------------------------------------------------
// annexb_start_code_splitter_top
// Annex B byte stream splitter: one byte in, NAL unit records out.
// ---------------------------------------------------------------------------
// The scanner takes one byte every clock cycle and stalls (full) only when
// the record queue of QUEUE_DEPTH entries is full. A byte that closes a unit
// and also ends the buffer yields two records, which leave as two successive
// output transfers; the drain delivers one record per cycle while pop is high
// and records are waiting. A record passes through the record queue and the
// drain register before it reaches the output. Offsets saturate at 2^32 - 1.
module annexb_start_code_splitter_top #(
  parameter int QUEUE_DEPTH = ascs_pkg::QUEUE_DEPTH_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ascs_pkg::in_item_t  in_data,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output ascs_pkg::out_item_t out_data
);
  import ascs_pkg::*;

  localparam int PAIR_W = $bits(rec_pair_t);

  logic      q_wr, q_rd, q_full, q_empty;
  rec_pair_t q_wdata, q_rdata;
  logic [PAIR_W-1:0] q_rbits;

  ascs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .q_full  (q_full),
    .full    (full),
    .q_wr    (q_wr),
    .q_data  (q_wdata)
  );

  ascs_fifo #(
    .WIDTH (PAIR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_data (q_rbits),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  assign q_rdata = rec_pair_t'(q_rbits);

  ascs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

>>> sv/ascs_fifo.sv
// ---------------------------------------------------------------------------
// ascs_fifo
// Small register queue between the scanner and the record drain.
// ---------------------------------------------------------------------------
module ascs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_full,
  output logic             q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == CNT_W'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> sv/ascs_front.sv
// ---------------------------------------------------------------------------
// ascs_front
// Byte scanner: tracks zero history and the pending unit, builds records.
// ---------------------------------------------------------------------------
module ascs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ascs_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              full,
  output logic              q_wr,
  output ascs_pkg::rec_pair_t q_data
);
  import ascs_pkg::*;

  logic [OFF_W-1:0]  pos_r, pos_nxt;
  logic [2:0]        zh_r, zh_nxt;
  logic              pv_r, pv_nxt;
  logic [OFF_W-1:0]  ps_r, ps_nxt;
  logic [OFF_W-1:0]  pp_r, pp_nxt;
  logic [TYPE_W-1:0] pt_r, pt_nxt;
  logic              aw_r, aw_nxt;

  logic              acc;
  logic              sc;
  logic [TYPE_W-1:0] type_now;
  logic [OFF_W-1:0]  start;
  logic [OFF_W-1:0]  pinc;
  logic              close_v, eob_v;
  rec_t              close_rec, eob_rec;

  assign full = q_full;
  assign acc  = push && !q_full;

  always_comb begin
    type_now = aw_r ? in_data.data_byte[TYPE_W-1:0] : pt_r;
    sc       = (in_data.data_byte == SC_BYTE) && (zh_r[1:0] == 2'b11);
    start    = zh_r[2] ? clamp_sub(pos_r, OFF_W'(3)) : clamp_sub(pos_r, OFF_W'(2));
    pinc     = sat_inc(pos_r);

    pos_nxt = pinc;
    if (sc) begin
      zh_nxt = '0;
      pv_nxt = 1'b1;
      ps_nxt = start;
      pp_nxt = pinc;
      pt_nxt = '0;
      aw_nxt = 1'b1;
    end else begin
      zh_nxt = {zh_r[1:0], in_data.data_byte == ZERO_BYTE};
      pv_nxt = pv_r;
      ps_nxt = ps_r;
      pp_nxt = pp_r;
      pt_nxt = type_now;
      aw_nxt = 1'b0;
    end

    close_v         = sc && pv_r;
    close_rec.start   = ps_r;
    close_rec.payload = pp_r;
    close_rec.size    = clamp_sub(start, pp_r);
    close_rec.utype   = type_now;

    eob_v           = in_data.end_of_buffer && pv_nxt;
    eob_rec.start   = ps_nxt;
    eob_rec.payload = pp_nxt;
    eob_rec.size    = clamp_sub(pinc, pp_nxt);
    eob_rec.utype   = pt_nxt;

    q_wr      = acc && (close_v || eob_v);
    q_data.r0 = close_v ? close_rec : eob_rec;
    q_data.r1 = eob_rec;
    q_data.two = close_v && eob_v;

    if (in_data.end_of_buffer) begin
      pos_nxt = '0;
      zh_nxt  = '0;
      pv_nxt  = 1'b0;
      ps_nxt  = '0;
      pp_nxt  = '0;
      pt_nxt  = '0;
      aw_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      zh_r  <= '0;
      pv_r  <= 1'b0;
      ps_r  <= '0;
      pp_r  <= '0;
      pt_r  <= '0;
      aw_r  <= 1'b0;
    end else if (acc) begin
      pos_r <= pos_nxt;
      zh_r  <= zh_nxt;
      pv_r  <= pv_nxt;
      ps_r  <= ps_nxt;
      pp_r  <= pp_nxt;
      pt_r  <= pt_nxt;
      aw_r  <= aw_nxt;
    end
  end

endmodule

>>> sv/ascs_back.sv
// ---------------------------------------------------------------------------
// ascs_back
// Record drain: unpacks queued record pairs into one transfer per record.
// ---------------------------------------------------------------------------
module ascs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ascs_pkg::rec_pair_t q_data,
  output logic                q_rd,
  output logic                empty,
  input  logic                pop,
  output ascs_pkg::out_item_t out_data
);
  import ascs_pkg::*;

  rec_pair_t cur_r;
  logic      vld_r, vld_nxt;
  logic      sel_r, sel_nxt;
  logic      take;
  logic      done;
  rec_t      rec;

  assign empty = !vld_r;
  assign take  = pop && vld_r;
  assign done  = take && (sel_r || !cur_r.two);
  assign q_rd  = !q_empty && (!vld_r || done);

  always_comb begin
    rec = sel_r ? cur_r.r1 : cur_r.r0;
    out_data.start_offset   = rec.start;
    out_data.body_offset    = rec.payload;
    out_data.payload_size   = rec.size;
    out_data.unit_type      = rec.utype;
    out_data.last_of_run    = sel_r || !cur_r.two;
  end

  always_comb begin
    vld_nxt = vld_r;
    sel_nxt = sel_r;
    if (q_rd) begin
      vld_nxt = 1'b1;
      sel_nxt = 1'b0;
    end else if (done) begin
      vld_nxt = 1'b0;
      sel_nxt = 1'b0;
    end else if (take) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_data;
    end
  end

endmodule

>>> tb/tb_annexb_start_code_splitter_top.sv
// ---------------------------------------------------------------------------
// tb_annexb_start_code_splitter_top
// Checks the Annex B splitter against a cycle-free scanner model kept here.
// Directed byte runs cover 3- and 4-byte start codes, back-to-back codes,
// a code on the last byte of a buffer and a buffer end with no unit open.
// Random traffic is mostly well-formed units with random payload, plus
// broken codes and noise, under several sender/receiver idle mixes and one
// long receiver hold that fills the record queue.
// ---------------------------------------------------------------------------
module tb_annexb_start_code_splitter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ascs_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_data = '0;
  logic      full;
  logic      empty;
  out_item_t out_data;

  annexb_start_code_splitter_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner model state
  logic [OFF_W-1:0]  scan_pos = '0;
  logic [2:0]        zero_hist = '0;
  logic              unit_open = 1'b0;
  logic [OFF_W-1:0]  unit_start = '0;
  logic [OFF_W-1:0]  unit_payload = '0;
  logic [TYPE_W-1:0] unit_kind = '0;
  logic              kind_wanted = 1'b0;

  out_item_t   expected_records[$];
  int          errors = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          bytes_sent = 0;

  function automatic logic [OFF_W-1:0] bump_pos(input logic [OFF_W-1:0] v);
    return (v == {OFF_W{1'b1}}) ? v : v + OFF_W'(1);
  endfunction

  function automatic logic [OFF_W-1:0] floor_sub(input logic [OFF_W-1:0] a,
                                                 input logic [OFF_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic out_item_t unit_record(input logic [OFF_W-1:0] size);
    out_item_t r;
    r.start_offset   = unit_start;
    r.body_offset    = unit_payload;
    r.payload_size   = size;
    r.unit_type      = unit_kind;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  task automatic predict_byte(input in_item_t it);
    out_item_t        recs[$];
    out_item_t        tail;
    logic [OFF_W-1:0] pos;
    logic [OFF_W-1:0] code_start;
    pos = scan_pos;
    if (kind_wanted) begin
      unit_kind   = it.data_byte[TYPE_W-1:0];
      kind_wanted = 1'b0;
    end
    if (it.data_byte == SC_BYTE && zero_hist[1:0] == 2'b11) begin
      code_start = zero_hist[2] ? floor_sub(pos, OFF_W'(3)) : floor_sub(pos, OFF_W'(2));
      if (unit_open) begin
        recs.insert(recs.size(), unit_record(floor_sub(code_start, unit_payload)));
      end
      unit_open    = 1'b1;
      unit_start   = code_start;
      unit_payload = bump_pos(pos);
      unit_kind    = '0;
      kind_wanted  = 1'b1;
      zero_hist    = '0;
    end else begin
      zero_hist = {zero_hist[1:0], it.data_byte == ZERO_BYTE};
    end
    scan_pos = bump_pos(pos);
    if (it.end_of_buffer) begin
      if (unit_open) begin
        recs.insert(recs.size(), unit_record(floor_sub(scan_pos, unit_payload)));
      end
      scan_pos     = '0;
      zero_hist    = '0;
      unit_open    = 1'b0;
      unit_start   = '0;
      unit_payload = '0;
      unit_kind    = '0;
      kind_wanted  = 1'b0;
    end
    if (recs.size() != 0) begin
      tail = recs[recs.size() - 1];
      tail.last_of_run = 1'b1;
      recs[recs.size() - 1] = tail;
    end
    foreach (recs[i]) expected_records.insert(expected_records.size(), recs[i]);
  endtask

  task automatic field_check(input string name, input logic [OFF_W-1:0] exp_v,
                             input logic [OFF_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_record(input out_item_t act);
    out_item_t exp_r;
    if (expected_records.size() == 0) begin
      errors++;
      $display("%0t: unexpected record, expected none, got %h", $time, act);
    end else begin
      exp_r = expected_records.pop_front();
      field_check("start_offset", exp_r.start_offset, act.start_offset);
      field_check("body_offset", exp_r.body_offset, act.body_offset);
      field_check("payload_size", exp_r.payload_size, act.payload_size);
      field_check("unit_type", OFF_W'(exp_r.unit_type), OFF_W'(act.unit_type));
      field_check("last_of_run", OFF_W'(exp_r.last_of_run), OFF_W'(act.last_of_run));
    end
  endtask

  // transfer monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) predict_byte(in_data);
      if (pop && !empty) check_record(out_data);
    end
  end

  // receiver
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 150;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= '{data_byte: b, end_of_buffer: eob};
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    push <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_records.size() != 0) begin
      errors++;
      $display("%0t: %0d records never arrived, expected %h, got none", $time,
               expected_records.size(), expected_records[0]);
      expected_records.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    return ($urandom_range(3) == 0) ? ZERO_BYTE : 8'($urandom_range(255));
  endfunction

  task automatic add_byte(ref in_item_t q[$], input logic [7:0] b);
    q.insert(q.size(), in_item_t'{data_byte: b, end_of_buffer: 1'b0});
  endtask

  task automatic append_unit(ref in_item_t q[$]);
    int unsigned mode;
    int unsigned len;
    in_item_t    tail;
    mode = $urandom_range(99);
    if (mode < 80) begin
      if ($urandom_range(1)) add_byte(q, ZERO_BYTE);
      add_byte(q, ZERO_BYTE);
      add_byte(q, ZERO_BYTE);
      add_byte(q, SC_BYTE);
      add_byte(q, 8'($urandom_range(255)));
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
      repeat (len) add_byte(q, payload_byte());
    end else if (mode < 90) begin
      repeat ($urandom_range(1, 6)) begin
        add_byte(q, ($urandom_range(2) != 0) ? ZERO_BYTE : SC_BYTE);
      end
    end else begin
      repeat ($urandom_range(1, 8)) add_byte(q, 8'($urandom_range(255)));
    end
    if ($urandom_range(5) == 0) begin
      tail = q[q.size() - 1];
      tail.end_of_buffer = 1'b1;
      q[q.size() - 1] = tail;
    end
  endtask

  task automatic test_directed_streams();
    gap_pct   = 0;
    stall_pct = 0;
    // 3-byte code, unit closed by a 4-byte code
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h65, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h9F, 1'b0);
    // code completes on the last byte: two records, new one empty
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
    // buffer end with no unit open
    send_byte(8'h00, 1'b1);
    // empty unit, then a unit whose header is all ones
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                     input int n_bytes);
    in_item_t chunk[$];
    int       stop_at;
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      chunk.delete();
      append_unit(chunk);
      foreach (chunk[i]) begin
        send_byte(chunk[i].data_byte,
                  chunk[i].end_of_buffer | ($urandom_range(49) == 0));
      end
    end
    wait_drained();
  endtask

  task automatic test_queue_backpressure();
    in_item_t chunk[$];
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    while (chunk.size() < 220) append_unit(chunk);
    foreach (chunk[i]) send_byte(chunk[i].data_byte, chunk[i].end_of_buffer);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_streams();
    test_random_traffic(0, 0, 290);
    test_random_traffic(72, 0, 290);
    test_random_traffic(0, 72, 290);
    test_random_traffic(13, 13, 290);
    test_queue_backpressure();
    wait_drained();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
